>>> rtl/life_automaton_torus_step_core_macros.svh
// assertion helpers shared by the checker files
`ifndef LIFE_AUTOMATON_TORUS_STEP_CORE_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_STEP_CORE_MACROS_SVH

// condition must hold at every clock edge out of reset
`define LATS_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("check failed: label");

// consequent must hold in the same cycle as the antecedent
`define LATS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed: label");

// consequent must hold in the cycle after the antecedent
`define LATS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed: label");

`endif

>>> rtl/lats_pkg.sv
package lats_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_COUNT,
    ST_ADVANCE,
    ST_DRAIN,
    ST_DONE
  } lats_state_e;

  // item operation codes, code 3 does nothing
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_ADVANCE = 2'd2
  } lats_action_e;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam int CFG_W      = 7;
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 13;
  localparam int GEN_W      = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]   DIM_RESET = 7'd64;

endpackage

>>> rtl/life_automaton_torus_step_core.sv
// life automaton on a torus, rule b3/s23, one-bit cells held as one row per memory word
//
// channels: input items on s_axis (tuser = action, tdata = row, column, cell value),
// results on m_axis, one result per item. config writes on cfg_we_i/cfg_idx_i/cfg_data_i
// set the active row and column counts and belong only in cycles where the block is idle.
//
// every item ends with a sweep over the active rows that recounts the live cells. an
// out-of-area access or the unused code skips the row access before that sweep.
// with nr active rows, an advance streams nr + 2 rows through a three-row window and
// writes each new row back in the same pass. the row memory has a single read port and
// a single write port.
// s_axis_tready_o is high only between items.
//
// after reset the block clears the cell memory, one row a cycle, all MAX_ROWS rows,
// before it accepts the first item. config registers reset to 64 rows by 64 columns.
//
// the result sits in an output register; a stalled receiver holds it there, the block
// may take the next item meanwhile but cannot hand over its result until the old one
// is taken.
module life_automaton_torus_step_core
  import lats_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // input items
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // row_index[5:0], col_index[11:6], cell_value[12], zero pad[15:13]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  logic [ACTION_W-1:0]    s_axis_tuser_i,
  // results
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // cell_out[0], live_count[13:1], all_dead[14], generation[30:15], out_of_range[31]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int AW    = $clog2(MAX_ROWS);      // row address
  localparam int RW    = $clog2(MAX_ROWS + 1);  // row count
  localparam int KW    = $clog2(MAX_ROWS + 2);  // sweep index, runs to nr + 1
  localparam int CAW   = $clog2(MAX_COLS);      // column address
  localparam int CW    = $clog2(MAX_COLS + 1);  // live cells in one row
  localparam int NCH   = (MAX_COLS + 7) / 8;    // byte lanes of the row popcount
  localparam int SUM_W = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

  typedef logic [MAX_COLS-1:0] row_t;

  // config registers
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [RW-1:0]    nr;
  logic [CAW:0]     nc;
  row_t             col_mask;

  // sequencer
  lats_state_e state_q, state_d;
  logic [KW-1:0] idx_q, idx_d;

  // item held for the whole operation
  logic [ACTION_W-1:0] act_q;
  logic [AW-1:0]       row_q;
  logic [CAW-1:0]      col_q;
  logic                val_q;
  logic                oor_q, cell_q;
  logic                in_oor;

  // control strobes from the sequencer
  logic          accept;
  logic          mem_rd_en;
  logic [AW-1:0] mem_raddr;
  logic          fsm_we;
  logic [AW-1:0] fsm_waddr;
  row_t          fsm_wdata;
  logic          sweep_issue, saved_issue;
  logic          cell_capture;
  logic          load_out;
  logic          pipe_empty;

  // row memory
  row_t          grid_mem [MAX_ROWS];
  row_t          rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  row_t          mem_wdata;

  // sweep pipeline: row arrival, masked row, byte counts, accumulate
  logic          rdv_q, sel_saved_q;
  logic [KW-1:0] tag_q;
  logic          adv_mode;
  row_t          elem, new_row;
  row_t          win0_q, win1_q, row0_q;
  logic          adv_we;
  logic          mv_q, mv_d;
  row_t          mrow_q, mrow_d;
  logic          bv_q;
  logic [3:0]    bc_q [NCH];
  logic [CW-1:0] row_sum;
  logic [SUM_W-1:0] acc_sum;
  logic [COUNT_W-1:0] acc_q;

  // output side
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic [GEN_W-1:0]       gen_q, gen_next;

  // ---------------------------------------------------------------------------
  // next row of the automaton for one row, wrap at the active column count
  // ---------------------------------------------------------------------------
  function automatic row_t life_row(input row_t up, input row_t cur, input row_t dn,
                                    input row_t mask, input logic [CAW-1:0] last);
    row_t       res;
    logic [7:0] nb;
    logic [3:0] n;
    res = cur;
    for (int c = 0; c < MAX_COLS; c++) begin
      nb[0] = (c == 0) ? up[last]  : up[(c + MAX_COLS - 1) % MAX_COLS];
      nb[1] = up[c];
      nb[2] = (c == int'(last)) ? up[0]  : up[(c + 1) % MAX_COLS];
      nb[3] = (c == 0) ? cur[last] : cur[(c + MAX_COLS - 1) % MAX_COLS];
      nb[4] = (c == int'(last)) ? cur[0] : cur[(c + 1) % MAX_COLS];
      nb[5] = (c == 0) ? dn[last]  : dn[(c + MAX_COLS - 1) % MAX_COLS];
      nb[6] = dn[c];
      nb[7] = (c == int'(last)) ? dn[0]  : dn[(c + 1) % MAX_COLS];
      n = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
        + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
      if (mask[c]) begin
        res[c] = (n == 4'd3) | (cur[c] & (n == 4'd2));
      end
    end
    return res;
  endfunction

  // live cells in one byte lane of a row
  function automatic logic [3:0] byte_count(input row_t r, input int j);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      if (j * 8 + b < MAX_COLS) begin
        n = n + 4'(r[j * 8 + b]);
      end
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // config: 0 acts as 1, above the maximum acts as the maximum
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ROWS) begin
        rows_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_COLS) begin
        cols_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (rows_q == '0) begin
      nr = RW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows_q);
    end
    if (cols_q == '0) begin
      nc = (CAW + 1)'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      nc = (CAW + 1)'(MAX_COLS);
    end else begin
      nc = (CAW + 1)'(cols_q);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(nc));
    end
  end

  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign in_oor = (int'(s_axis_tdata_i[INDEX_W-1:0]) >= int'(nr)) ||
                  (int'(s_axis_tdata_i[2*INDEX_W-1:INDEX_W]) >= int'(nc));

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (idx_q == KW'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((s_axis_tuser_i inside {ACT_WRITE, ACT_READ}) && !in_oor) begin
            state_d = ST_CELL_RD;
          end else if (s_axis_tuser_i == ACT_ADVANCE) begin
            state_d = ST_ADVANCE;
          end else begin
            state_d = ST_COUNT;
          end
        end
      end
      ST_CELL_RD: state_d = ST_CELL_WR;
      ST_CELL_WR: state_d = ST_COUNT;
      ST_COUNT: begin
        if (idx_q == KW'(nr - RW'(1))) begin
          state_d = ST_DRAIN;
        end
      end
      ST_ADVANCE: begin
        if (idx_q == KW'(nr) + KW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: strobes and sweep index
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = 1'b0;
    idx_d           = idx_q;
    mem_rd_en       = 1'b0;
    mem_raddr       = idx_q[AW-1:0];
    fsm_we          = 1'b0;
    fsm_waddr       = row_q;
    fsm_wdata       = rd_data_q;
    sweep_issue     = 1'b0;
    saved_issue     = 1'b0;
    cell_capture    = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        fsm_we    = 1'b1;
        fsm_waddr = idx_q[AW-1:0];
        fsm_wdata = '0;
        idx_d     = (idx_q == KW'(MAX_ROWS - 1)) ? '0 : idx_q + KW'(1);
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        idx_d           = '0;
      end
      ST_CELL_RD: begin
        mem_rd_en = 1'b1;
        mem_raddr = row_q;
      end
      ST_CELL_WR: begin
        // write back the row with one bit changed, or just pick the bit
        cell_capture          = (act_q == ACT_READ);
        fsm_we                = (act_q == ACT_WRITE);
        fsm_wdata[col_q]      = val_q;
        idx_d                 = '0;
      end
      ST_COUNT: begin
        mem_rd_en   = 1'b1;
        sweep_issue = 1'b1;
        idx_d       = idx_q + KW'(1);
      end
      ST_ADVANCE: begin
        // stream: row nr-1, rows 0..nr-1, then the saved copy of old row 0
        if (idx_q == KW'(nr) + KW'(1)) begin
          saved_issue = 1'b1;
        end else begin
          mem_rd_en   = 1'b1;
          sweep_issue = 1'b1;
          mem_raddr   = (idx_q == '0) ? AW'(nr - RW'(1)) : AW'(idx_q - KW'(1));
        end
        idx_d = idx_q + KW'(1);
      end
      ST_DRAIN: ;
      ST_DONE: begin
        load_out = !m_valid_q || m_axis_tready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // item registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= s_axis_tuser_i;
      row_q  <= AW'(s_axis_tdata_i[INDEX_W-1:0]);
      col_q  <= CAW'(s_axis_tdata_i[2*INDEX_W-1:INDEX_W]);
      val_q  <= s_axis_tdata_i[2*INDEX_W];
      oor_q  <= in_oor && (s_axis_tuser_i inside {ACT_WRITE, ACT_READ});
      cell_q <= 1'b0;
    end else if (cell_capture) begin
      cell_q <= rd_data_q[col_q];
    end
  end

  // ---------------------------------------------------------------------------
  // row memory, one write and one read port
  // ---------------------------------------------------------------------------
  assign mem_we    = fsm_we | adv_we;
  assign mem_waddr = adv_we ? AW'(tag_q - KW'(2)) : fsm_waddr;
  assign mem_wdata = adv_we ? new_row : fsm_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      rd_data_q <= grid_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // sweep: window update on advance, then popcount and accumulate
  // ---------------------------------------------------------------------------
  assign adv_mode = (act_q == ACT_ADVANCE);
  assign elem     = sel_saved_q ? row0_q : rd_data_q;
  assign new_row  = life_row(win0_q, win1_q, elem, col_mask, CAW'(nc - (CAW + 1)'(1)));
  assign adv_we   = rdv_q && adv_mode && (tag_q >= KW'(2));

  assign mv_d   = rdv_q && (!adv_mode || (tag_q >= KW'(2)));
  assign mrow_d = (adv_mode ? new_row : elem) & col_mask;

  always_comb begin
    row_sum = '0;
    for (int j = 0; j < NCH; j++) begin
      row_sum = row_sum + CW'(bc_q[j]);
    end
    acc_sum = SUM_W'(acc_q) + SUM_W'(row_sum);
  end

  assign pipe_empty = !rdv_q && !mv_q && !bv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
      mv_q  <= 1'b0;
      bv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      rdv_q <= sweep_issue | saved_issue;
      mv_q  <= mv_d;
      bv_q  <= mv_q;
      if (accept) begin
        acc_q <= '0;
      end else if (bv_q) begin
        // saturating live count
        acc_q <= (acc_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : acc_sum[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_saved_q <= saved_issue;
    tag_q       <= idx_q;
    mrow_q      <= mrow_d;
    if (rdv_q && adv_mode) begin
      win0_q <= win1_q;
      win1_q <= elem;
      if (tag_q == KW'(1)) begin
        row0_q <= elem;
      end
    end
    for (int j = 0; j < NCH; j++) begin
      bc_q[j] <= byte_count(mrow_q, j);
    end
  end

  // ---------------------------------------------------------------------------
  // generation counter and output register
  // ---------------------------------------------------------------------------
  assign gen_next = adv_mode ? gen_q + GEN_W'(1) : gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        gen_q <= gen_next;
      end
      m_valid_q <= load_out | (m_valid_q & !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {oor_q, gen_next, (acc_q == '0), acc_q, cell_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

>>> rtl/lats_checker.sv
`include "life_automaton_torus_step_core_macros.svh"

module lats_checker
  import lats_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // all_dead agrees with the live count
  `LATS_ASSERT_IMP(a_all_dead, m_axis_tvalid_o,
                   m_axis_tdata_o[14] == (m_axis_tdata_o[13:1] == '0))

  // an out of range access never returns a live cell
  `LATS_ASSERT_IMP(a_oor_cell, m_axis_tvalid_o && m_axis_tdata_o[31], !m_axis_tdata_o[0])

  // the block works on one item at a time
  `LATS_ASSERT_NXT(a_busy, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // a stalled result holds
  `LATS_ASSERT_NXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind life_automaton_torus_step_core lats_checker u_lats_checker (.*);

>>> verif/tb_life_automaton_torus_step_core.sv
module tb_life_automaton_torus_step_core;
  import lats_pkg::*;

  localparam int GRID         = 64;
  localparam int RANDOM_ITEMS = 1850;
  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // wait after the last result, long enough for one item at full board size with slack
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_SHOWN    = 10;
  // slots for results still owed, the block never owes more than two
  localparam int PEND_DEPTH   = 16;
  // unused action code, the block only reports status
  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  // result layout, declared msb first so it overlays m_axis_tdata directly
  typedef struct packed {
    logic               oor;
    logic [GEN_W-1:0]   gen;
    logic               dead;
    logic [COUNT_W-1:0] live;
    logic               cell_out;
  } life_status_t;

  // one row of the directed table: either a board resize or an item
  typedef struct {
    bit                  is_cfg;
    logic [CFG_W-1:0]    rows;
    logic [CFG_W-1:0]    cols;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  row;
    logic [INDEX_W-1:0]  col;
    logic                val;
    bit                  typed;
    life_status_t        want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // config port
  logic             cfg_we   = 1'b0;
  logic             cfg_idx  = CFG_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  // item input side
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // row_index[5:0], col_index[11:6], cell_value[12], zero pad[15:13]
  logic [IN_TDATA_W-1:0] s_tdata  = '0;
  // action[1:0]
  logic [ACTION_W-1:0]   s_tuser  = '0;

  // result side
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // cell_out[0], live_count[13:1], all_dead[14], generation[30:15], out_of_range[31]
  logic [OUT_TDATA_W-1:0] m_tdata;

  // shadow of the board, the generation counter and the two dimension registers
  bit   [GRID-1:0]  life_cells [GRID];
  logic [CFG_W-1:0] rows_reg  = DIM_RESET;
  logic [CFG_W-1:0] cols_reg  = DIM_RESET;
  logic [GEN_W-1:0] gen_count = '0;

  // status words still owed by the block, ring read at head, written at tail
  life_status_t pending_ring [PEND_DEPTH];
  int pend_head = 0;
  int pend_tail = 0;

  // no random idling on either side while set
  bit quiet = 1'b0;

  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int advances     = 0;
  int oor_hits     = 0;
  int board_setups = 0;
  int idle_cycles  = 0;

  stim_row_t directed [25];

  life_automaton_torus_step_core #(
    .MAX_ROWS(GRID),
    .MAX_COLS(GRID)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always #1 clk_i = ~clk_i;

  // register value to active size: zero acts as one, above the grid acts as the grid
  function automatic int active_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID) return GRID;
    return int'(v);
  endfunction

  // apply one item to the shadow board and work out the status it returns
  task automatic predict_status(input logic [ACTION_W-1:0] act,
                                input logic [INDEX_W-1:0] row, input logic [INDEX_W-1:0] col,
                                input logic val, output life_status_t st);
    int nr, nc, n, up, dn, lf, rt, total;
    bit [GRID-1:0] nxt [GRID];
    nr = active_dim(rows_reg);
    nc = active_dim(cols_reg);
    st = '0;
    if (act == ACT_WRITE || act == ACT_READ) begin
      if (row >= nr || col >= nc) begin
        st.oor = 1'b1;
      end else if (act == ACT_WRITE) begin
        life_cells[row][col] = val;
      end else begin
        st.cell_out = life_cells[row][col];
      end
    end else if (act == ACT_ADVANCE) begin
      // every new cell comes from the old board, cells outside the area stay put
      nxt = life_cells;
      for (int r = 0; r < nr; r++) begin
        up = (r == 0) ? nr - 1 : r - 1;
        dn = (r + 1 == nr) ? 0 : r + 1;
        for (int c = 0; c < nc; c++) begin
          lf = (c == 0) ? nc - 1 : c - 1;
          rt = (c + 1 == nc) ? 0 : c + 1;
          // each of the eight positions counts, even when they alias on a tiny torus
          n = 0;
          n += life_cells[up][lf]; n += life_cells[up][c]; n += life_cells[up][rt];
          n += life_cells[r][lf];                          n += life_cells[r][rt];
          n += life_cells[dn][lf]; n += life_cells[dn][c]; n += life_cells[dn][rt];
          if (life_cells[r][c] && (n <= 1 || n >= 4)) nxt[r][c] = 1'b0;
          else if (!life_cells[r][c] && n == 3) nxt[r][c] = 1'b1;
        end
      end
      life_cells = nxt;
      gen_count++;
    end
    total = 0;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        total += life_cells[r][c];
    if (total > 8191) total = 8191;
    st.live = total[COUNT_W-1:0];
    st.dead = (total == 0);
    st.gen  = gen_count;
  endtask

  // offer one item, wait for it to be taken, then log what it should return
  task automatic push_item(input logic [ACTION_W-1:0] act,
                           input logic [INDEX_W-1:0] row, input logic [INDEX_W-1:0] col,
                           input logic val, input bit typed, input life_status_t typed_st);
    life_status_t st;
    if (!quiet && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, val, col, row};
    do @(posedge clk_i); while (!s_tready);
    predict_status(act, row, col, val, st);
    // typed rows carry a hand-written answer, the board shadow still moves on
    pending_ring[pend_tail % PEND_DEPTH] = typed ? typed_st : st;
    pend_tail++;
    items_sent++;
    if (act == ACT_ADVANCE) advances++;
    if (st.oor) oor_hits++;
  endtask

  // resize the board once everything in flight has been handed back
  task automatic write_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pend_tail != pend_head || !s_tready);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROWS;
    cfg_data <= r;
    @(posedge clk_i);
    rows_reg = r;
    cfg_idx  <= CFG_COLS;
    cfg_data <= c;
    @(posedge clk_i);
    cols_reg = c;
    cfg_we   <= 1'b0;
    board_setups++;
  endtask

  // receiver: take results, compare them with the oldest expectation, stall at random
  always @(posedge clk_i) begin : result_check
    life_status_t want, got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pend_tail == pend_head) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result %h with nothing pending", m_tdata);
      end else begin
        want = pending_ring[pend_head % PEND_DEPTH];
        pend_head++;
        results_seen++;
        if (got.cell_out !== want.cell_out || got.live !== want.live ||
            got.dead !== want.dead || got.gen !== want.gen || got.oor !== want.oor) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: want cell=%0d live=%0d dead=%0d gen=%0d oor=%0d,",
                     results_seen, want.cell_out, want.live, want.dead, want.gen,
                     want.oor, " got cell=%0d live=%0d dead=%0d gen=%0d oor=%0d",
                     got.cell_out, got.live, got.dead, got.gen, got.oor);
        end
      end
    end
    m_tready <= quiet || ($urandom_range(99) >= 13);
  end

  // hang detector: counts cycles without a handshake on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results pending", idle_cycles,
               pend_tail - pend_head);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int nr, nc, sel, n_body, phase, random_goal;
    logic [INDEX_W-1:0] row, col;
    logic [ACTION_W-1:0] act;
    logic [CFG_W-1:0] rows_pick, cols_pick;
    logic [CFG_W-1:0] extremes [6];
    extremes = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};

    // positional fields: is_cfg, rows, cols, action, row, col, value, typed,
    // status as {oor, generation, all_dead, live_count, cell_out}
    directed = '{
      // empty board after reset
      '{0, 0, 0, ACT_READ,    0,  0,  0, 1, '{0, 0, 1, 0, 0}},
      // an empty board stays empty but the generation still counts
      '{0, 0, 0, ACT_ADVANCE, 0,  0,  0, 1, '{0, 1, 1, 0, 0}},
      // far corner
      '{0, 0, 0, ACT_WRITE,   63, 63, 1, 1, '{0, 1, 0, 1, 0}},
      '{0, 0, 0, ACT_READ,    63, 63, 0, 1, '{0, 1, 0, 1, 1}},
      // horizontal blinker straddling the column wrap
      '{0, 0, 0, ACT_WRITE,   0,  63, 1, 0, '0},
      '{0, 0, 0, ACT_WRITE,   0,  0,  1, 0, '0},
      '{0, 0, 0, ACT_WRITE,   0,  1,  1, 0, '0},
      '{0, 0, 0, ACT_ADVANCE, 0,  0,  0, 0, '0},
      '{0, 0, 0, ACT_READ,    1,  0,  0, 0, '0},
      '{0, 0, 0, ACT_ADVANCE, 0,  0,  0, 0, '0},
      // unused code with every field at its top
      '{0, 0, 0, ACT_NOP,     63, 63, 1, 0, '0},
      // zero rows acts as one, two columns: neighbours alias onto the cell itself
      '{1, 0, 2, ACT_READ,    0,  0,  0, 0, '0},
      '{0, 0, 0, ACT_WRITE,   0,  1,  1, 0, '0},
      '{0, 0, 0, ACT_READ,    1,  0,  0, 0, '0},
      '{0, 0, 0, ACT_ADVANCE, 0,  0,  0, 0, '0},
      '{0, 0, 0, ACT_WRITE,   0,  2,  1, 0, '0},
      // oversized registers clamp to the full grid, hidden cells come back
      '{1, 127, 65, ACT_READ, 0,  0,  0, 0, '0},
      '{0, 0, 0, ACT_READ,    63, 63, 0, 0, '0},
      '{0, 0, 0, ACT_ADVANCE, 0,  0,  0, 0, '0},
      // smallest regular torus
      '{1, 3, 3, ACT_READ,    0,  0,  0, 0, '0},
      '{0, 0, 0, ACT_WRITE,   1,  1,  1, 0, '0},
      '{0, 0, 0, ACT_WRITE,   3,  3,  1, 0, '0},
      '{0, 0, 0, ACT_ADVANCE, 0,  0,  0, 0, '0},
      '{1, 64, 64, ACT_READ,  0,  0,  0, 0, '0},
      '{0, 0, 0, ACT_READ,    2,  2,  0, 0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_dims(directed[i].rows, directed[i].cols);
      else push_item(directed[i].act, directed[i].row, directed[i].col, directed[i].val,
                     directed[i].typed, directed[i].want);
    end

    // random part: each phase sets a board size, seeds a pattern and then runs it
    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_goal) begin
      case (phase % 6)
        0: begin
          rows_pick = extremes[$urandom_range(5)];
          cols_pick = extremes[$urandom_range(5)];
        end
        4: begin
          rows_pick = CFG_W'($urandom_range(16, 3));
          cols_pick = CFG_W'($urandom_range(16, 3));
        end
        5: begin
          rows_pick = CFG_W'($urandom_range(64, 17));
          cols_pick = CFG_W'($urandom_range(64, 17));
        end
        default: begin
          rows_pick = CFG_W'($urandom_range(8, 1));
          cols_pick = CFG_W'($urandom_range(8, 1));
        end
      endcase
      // the resize waits for every result, so the sender drains here each phase
      write_dims(rows_pick, cols_pick);
      quiet = (phase == 3);
      nr = active_dim(rows_reg);
      nc = active_dim(cols_reg);

      // seed a cluster in the top-left corner so that patterns interact
      repeat ((nr * nc < 24) ? nr * nc : 24)
        push_item(ACT_WRITE, INDEX_W'($urandom_range((nr < 8 ? nr : 8) - 1)),
                  INDEX_W'($urandom_range((nc < 8 ? nc : 8) - 1)),
                  $urandom_range(99) < 40, 1'b0, '0);

      n_body = $urandom_range(90, 40);
      repeat (n_body) begin
        sel = $urandom_range(99);
        row = INDEX_W'($urandom_range(nr - 1));
        col = INDEX_W'($urandom_range(nc - 1));
        if (sel < 35) begin
          push_item(ACT_ADVANCE, INDEX_W'($urandom_range(63)), INDEX_W'($urandom_range(63)),
                    1'($urandom_range(1)), 1'b0, '0);
        end else if (sel < 55) begin
          push_item(ACT_READ, row, col, 1'($urandom_range(1)), 1'b0, '0);
        end else if (sel < 80) begin
          push_item(ACT_WRITE, row, col, 1'($urandom_range(1)), 1'b0, '0);
        end else if (sel < 90) begin
          // reach past the active area where there is room for it
          if (nr < GRID && (nc == GRID || $urandom_range(1))) begin
            row = INDEX_W'($urandom_range(GRID - 1, nr));
            col = INDEX_W'($urandom_range(63));
          end else if (nc < GRID) begin
            col = INDEX_W'($urandom_range(GRID - 1, nc));
            row = INDEX_W'($urandom_range(63));
          end
          act = $urandom_range(1) ? ACT_WRITE : ACT_READ;
          push_item(act, row, col, 1'($urandom_range(1)), 1'b0, '0);
        end else if (sel < 95) begin
          push_item(ACT_NOP, INDEX_W'($urandom_range(63)), INDEX_W'($urandom_range(63)),
                    1'($urandom_range(1)), 1'b0, '0);
        end else begin
          push_item(ACTION_W'($urandom_range(3)), INDEX_W'($urandom_range(63)),
                    INDEX_W'($urandom_range(63)), 1'($urandom_range(1)), 1'b0, '0);
        end
      end
      phase++;
    end
    quiet = 1'b0;

    // drain everything still owed, then give the block time for a stray result
    s_tvalid <= 1'b0;
    while (pend_tail != pend_head) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d items (%0d generations stepped, %0d out-of-area accesses)",
             items_sent, advances, oor_hits);
    $display("over %0d board sizes, %0d results checked, %0d mismatches",
             board_setups, results_seen, mismatches);
    if (mismatches == 0 && pend_tail == pend_head) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
